/* hw/rtl/crp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_pkg: shared types and constants of the replay record parser
// Result item layout, result codes, character helpers.
// ----------------------------------------------------------------------------
package crp_pkg;

    localparam logic [1:0] RES_BYTE  = 2'd0;
    localparam logic [1:0] RES_DONE  = 2'd1;
    localparam logic [1:0] RES_ERROR = 2'd2;

    localparam int COUNT_W    = 11;
    localparam logic [3:0] HEADER_LEN = 4'd12;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_T     = 8'h74;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         pbyte;
        logic [COUNT_W-1:0] idx;
        logic [63:0]        ts;
        logic [17:0]        grp;
        logic [7:0]         snd;
        logic [COUNT_W-1:0] cnt;
        logic [31:0]        line;
    } res_t;

    // Expected character at each position of the header line keyword
    function automatic logic [7:0] header_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h74; // t
            4'd1:    c = 8'h69; // i
            4'd2:    c = 8'h6D; // m
            4'd3:    c = 8'h65; // e
            4'd4:    c = 8'h73; // s
            4'd5:    c = 8'h74; // t
            4'd6:    c = 8'h61; // a
            4'd7:    c = 8'h6D; // m
            4'd8:    c = 8'h70; // p
            4'd9:    c = 8'h5F; // _
            4'd10:   c = 8'h6D; // m
            4'd11:   c = 8'h73; // s
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Hex digit decode: bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C)
            || (c == 8'h0D);
    endfunction

endpackage

/* hw/rtl/crp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_front: character classifier and record parser
// Consume one character per cycle while take is high and the parser is not stopped, and form at most one result item.
// ----------------------------------------------------------------------------
module crp_front #(
    parameter int MAX_PAYLOAD_BYTES = 1785
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    ch,
    input  logic          end_of_stream,
    output logic          push,
    output crp_pkg::res_t res,
    output logic          stopped
);

    typedef enum logic [2:0] {
        PH_START, PH_HEADER, PH_SKIP, PH_NUMBER, PH_PAYLOAD
    } phase_t;

    typedef enum logic [1:0] {
        BASE_NONE, BASE_DEC, BASE_OCT, BASE_HEX
    } base_t;

    localparam int CW = crp_pkg::COUNT_W;

    phase_t          phase_reg, phase_next;
    base_t           base_reg, base_next;
    logic [1:0]      fpos_reg, fpos_next;
    logic [63:0]     acc_reg, acc_next;
    logic            sign_reg, sign_next;
    logic            neg_reg, neg_next;
    logic            digit_reg, digit_next;
    logic            trail_reg, trail_next;
    logic [63:0]     ts_reg, ts_next;
    logic [17:0]     grp_reg, grp_next;
    logic [7:0]      snd_reg, snd_next;
    logic            nv_reg, nv_next;
    logic [3:0]      nib_reg, nib_next;
    logic [CW-1:0]   pcount_reg, pcount_next;
    logic [3:0]      hcnt_reg, hcnt_next;
    logic [7:0]      last_reg, last_next;
    logic [31:0]     line_reg, line_next;
    logic            stop_reg, stop_next;

    logic            fail_c;
    logic [31:0]     line_now;
    logic [4:0]      hexd;
    logic [67:0]     dec_sum;
    logic [63:0]     neg_val;
    logic [7:0]      pbyte;
    logic            do_num;

    assign hexd     = crp_pkg::hex_digit(ch);
    assign line_now = (line_reg == 32'hFFFF_FFFF) ? line_reg : line_reg + 32'd1;
    assign dec_sum  = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                    + {64'd0, ch[3:0]};
    assign neg_val  = neg_reg ? (64'd0 - acc_reg) : acc_reg;
    assign pbyte    = {nib_reg, hexd[3:0]};

    always_comb
    begin
        phase_next  = phase_reg;
        base_next   = base_reg;
        fpos_next   = fpos_reg;
        acc_next    = acc_reg;
        sign_next   = sign_reg;
        neg_next    = neg_reg;
        digit_next  = digit_reg;
        trail_next  = trail_reg;
        ts_next     = ts_reg;
        grp_next    = grp_reg;
        snd_next    = snd_reg;
        nv_next     = nv_reg;
        nib_next    = nib_reg;
        pcount_next = pcount_reg;
        hcnt_next   = hcnt_reg;
        last_next   = last_reg;
        line_next   = line_reg;
        stop_next   = stop_reg;
        fail_c      = 1'b0;
        do_num      = 1'b0;
        push        = 1'b0;
        res         = '0;

        if (take && !stop_reg)
        begin
            // per-character work
            if (ch != crp_pkg::CH_NUL && ch != crp_pkg::CH_NL)
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        if (crp_pkg::is_blank(ch))
                            phase_next = PH_START;
                        else if (ch == crp_pkg::CH_HASH)
                            phase_next = PH_SKIP;
                        else if (ch == crp_pkg::CH_T)
                        begin
                            phase_next = PH_HEADER;
                            hcnt_next  = 4'd1;
                        end
                        else
                        begin
                            phase_next = PH_NUMBER;
                            do_num     = 1'b1;
                        end
                    end
                    PH_HEADER:
                    begin
                        if (hcnt_reg < crp_pkg::HEADER_LEN
                            && ch == crp_pkg::header_char(hcnt_reg))
                        begin
                            hcnt_next = hcnt_reg + 4'd1;
                            if (hcnt_next >= crp_pkg::HEADER_LEN)
                                phase_next = PH_SKIP;
                        end
                        else
                            fail_c = 1'b1;
                    end
                    PH_NUMBER:
                        do_num = 1'b1;
                    PH_PAYLOAD:
                    begin
                        if (crp_pkg::is_blank(ch) || ch == crp_pkg::CH_COLON
                            || ch == crp_pkg::CH_MINUS)
                            nv_next = nv_reg;
                        else if (!hexd[4])
                            fail_c = 1'b1;
                        else if (!nv_reg)
                        begin
                            nv_next  = 1'b1;
                            nib_next = hexd[3:0];
                        end
                        else if (pcount_reg >= CW'(MAX_PAYLOAD_BYTES))
                            fail_c = 1'b1;
                        else
                        begin
                            nv_next     = 1'b0;
                            last_next   = pbyte;
                            push        = 1'b1;
                            res.kind    = crp_pkg::RES_BYTE;
                            res.pbyte   = pbyte;
                            res.idx     = pcount_reg;
                            res.ts      = ts_reg;
                            res.grp     = grp_reg;
                            res.snd     = snd_reg;
                            res.cnt     = '0;
                            res.line    = line_now;
                            pcount_next = pcount_reg + CW'(1);
                        end
                    end
                    default:
                        phase_next = phase_reg;
                endcase

                if (do_num)
                begin
                    if (ch == crp_pkg::CH_COMMA)
                    begin
                        // close the field
                        if (base_reg == BASE_NONE || (base_reg == BASE_HEX && !digit_reg)
                            || fpos_reg == 2'd3)
                            fail_c = 1'b1;
                        else if (fpos_reg == 2'd1 && neg_val[63:18] != '0)
                            fail_c = 1'b1;
                        else if (fpos_reg == 2'd2 && neg_val[63:8] != '0)
                            fail_c = 1'b1;
                        else
                        begin
                            case (fpos_reg)
                                2'd0:    ts_next  = neg_val;
                                2'd1:    grp_next = neg_val[17:0];
                                default: snd_next = neg_val[7:0];
                            endcase
                            acc_next   = '0;
                            base_next  = BASE_NONE;
                            sign_next  = 1'b0;
                            neg_next   = 1'b0;
                            digit_next = 1'b0;
                            trail_next = 1'b0;
                            fpos_next  = fpos_reg + 2'd1;
                            if (fpos_reg == 2'd2)
                            begin
                                phase_next  = PH_PAYLOAD;
                                nv_next     = 1'b0;
                                nib_next    = '0;
                                pcount_next = '0;
                            end
                        end
                    end
                    else if (crp_pkg::is_blank(ch))
                    begin
                        if (base_reg == BASE_NONE && !sign_reg)
                            trail_next = trail_reg;
                        else if (base_reg == BASE_NONE)
                            fail_c = 1'b1;
                        else if (base_reg == BASE_HEX && !digit_reg)
                            fail_c = 1'b1;
                        else
                            trail_next = 1'b1;
                    end
                    else if (trail_reg)
                        fail_c = 1'b1;
                    else if (base_reg == BASE_NONE)
                    begin
                        if (!sign_reg && (ch == crp_pkg::CH_PLUS || ch == crp_pkg::CH_MINUS))
                        begin
                            sign_next = 1'b1;
                            neg_next  = (ch == crp_pkg::CH_MINUS);
                        end
                        else if (ch == crp_pkg::CH_ZERO)
                            base_next = BASE_OCT;
                        else if (ch >= 8'h31 && ch <= 8'h39)
                        begin
                            base_next  = BASE_DEC;
                            acc_next   = {60'd0, ch[3:0]};
                            digit_next = 1'b1;
                        end
                        else
                            fail_c = 1'b1;
                    end
                    else if (base_reg == BASE_OCT && !digit_reg
                             && (ch == 8'h78 || ch == 8'h58))
                        base_next = BASE_HEX;
                    else if (base_reg == BASE_DEC)
                    begin
                        if (ch < 8'h30 || ch > 8'h39 || dec_sum[67:64] != '0)
                            fail_c = 1'b1;
                        else
                        begin
                            acc_next   = dec_sum[63:0];
                            digit_next = 1'b1;
                        end
                    end
                    else if (base_reg == BASE_OCT)
                    begin
                        if (ch < 8'h30 || ch > 8'h37 || acc_reg[63:61] != '0)
                            fail_c = 1'b1;
                        else
                        begin
                            acc_next   = {acc_reg[60:0], ch[2:0]};
                            digit_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (!hexd[4] || acc_reg[63:60] != '0)
                            fail_c = 1'b1;
                        else
                        begin
                            acc_next   = {acc_reg[59:0], hexd[3:0]};
                            digit_next = 1'b1;
                        end
                    end
                end
            end

            // line end work on the state left by this character
            if (!fail_c && (ch == crp_pkg::CH_NUL || ch == crp_pkg::CH_NL || end_of_stream))
            begin
                if (phase_next == PH_HEADER || phase_next == PH_NUMBER)
                    fail_c = 1'b1;
                else if (phase_next == PH_PAYLOAD)
                begin
                    if (nv_next || pcount_next == '0)
                        fail_c = 1'b1;
                    else
                    begin
                        push      = 1'b1;
                        res.kind  = crp_pkg::RES_DONE;
                        res.pbyte = last_next;
                        res.idx   = pcount_next - CW'(1);
                        res.ts    = ts_next;
                        res.grp   = grp_next;
                        res.snd   = snd_next;
                        res.cnt   = pcount_next;
                        res.line  = line_now;
                    end
                end

                if (!fail_c)
                begin
                    phase_next  = (ch == crp_pkg::CH_NUL) ? PH_SKIP : PH_START;
                    fpos_next   = '0;
                    acc_next    = '0;
                    base_next   = BASE_NONE;
                    sign_next   = 1'b0;
                    neg_next    = 1'b0;
                    digit_next  = 1'b0;
                    trail_next  = 1'b0;
                    ts_next     = '0;
                    grp_next    = '0;
                    snd_next    = '0;
                    nv_next     = 1'b0;
                    nib_next    = '0;
                    pcount_next = '0;
                    hcnt_next   = '0;
                    last_next   = '0;
                    if (ch == crp_pkg::CH_NL || end_of_stream)
                    begin
                        phase_next = PH_START;
                        line_next  = line_now;
                    end
                end
            end

            if (fail_c)
            begin
                stop_next = 1'b1;
                push      = 1'b1;
                res       = '0;
                res.kind  = crp_pkg::RES_ERROR;
                res.line  = line_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            base_reg   <= BASE_NONE;
            fpos_reg   <= '0;
            acc_reg    <= '0;
            sign_reg   <= 1'b0;
            neg_reg    <= 1'b0;
            digit_reg  <= 1'b0;
            trail_reg  <= 1'b0;
            ts_reg     <= '0;
            grp_reg    <= '0;
            snd_reg    <= '0;
            nv_reg     <= 1'b0;
            nib_reg    <= '0;
            pcount_reg <= '0;
            hcnt_reg   <= '0;
            last_reg   <= '0;
            line_reg   <= '0;
            stop_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            base_reg   <= base_next;
            fpos_reg   <= fpos_next;
            acc_reg    <= acc_next;
            sign_reg   <= sign_next;
            neg_reg    <= neg_next;
            digit_reg  <= digit_next;
            trail_reg  <= trail_next;
            ts_reg     <= ts_next;
            grp_reg    <= grp_next;
            snd_reg    <= snd_next;
            nv_reg     <= nv_next;
            nib_reg    <= nib_next;
            pcount_reg <= pcount_next;
            hcnt_reg   <= hcnt_next;
            last_reg   <= last_next;
            line_reg   <= line_next;
            stop_reg   <= stop_next;
        end
    end

    assign stopped = stop_reg;

endmodule

/* hw/rtl/crp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_queue: result item queue
// Four-entry FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
module crp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  crp_pkg::res_t push_data,
    input  logic          pop,
    output crp_pkg::res_t head,
    output logic          not_empty,
    output logic          not_full,
    output logic [2:0]    level
);

    crp_pkg::res_t mem [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_next  = push ? wr_reg + 2'd1 : wr_reg;
        rd_next  = pop ? rd_reg + 2'd1 : rd_reg;
        cnt_next = cnt_reg + {2'd0, push} - {2'd0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    assign head      = mem[rd_reg];
    assign not_empty = (cnt_reg != 3'd0);
    assign not_full  = (cnt_reg != 3'd4);
    assign level     = cnt_reg;

endmodule

/* hw/rtl/crp_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_out: result output register
// Load the next queued item whenever the output slot is free or taken.
// ----------------------------------------------------------------------------
module crp_out (
    input  logic          clk,
    input  logic          rst_n,
    input  crp_pkg::res_t head,
    input  logic          not_empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output crp_pkg::res_t data
);

    logic          valid_reg, valid_next;
    crp_pkg::res_t data_reg, data_next;

    always_comb
    begin
        pop        = not_empty && (!valid_reg || out_ready);
        valid_next = pop ? 1'b1 : (valid_reg && !out_ready);
        data_next  = pop ? head : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign data      = data_reg;

endmodule

/* hw/rtl/can_replay_record_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_replay_record_parser: replay text record parser
// A result item passes through the result queue and then the output register.
// Throughput: 1 character per cycle while the result queue is not full.
// Input stalls only when the 4-entry result queue is full.
// Reset: asynchronous, active low; clears parser state, queue and output.
// ----------------------------------------------------------------------------
module can_replay_record_parser #(
    parameter int MAX_PAYLOAD_BYTES = 1785
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  payload_byte,
    output logic [10:0] byte_index,
    output logic [63:0] timestamp_value,
    output logic [17:0] group_number,
    output logic [7:0]  sender_address,
    output logic [10:0] byte_count,
    output logic [31:0] text_line
);

    // Front: parse each accepted character and form at most one item.
    // Queue: decouple the parser from output back-pressure.
    // Back: registered output slot.

    logic          take;
    logic          push;
    logic          pop;
    logic          stopped;
    logic          not_empty;
    logic          not_full;
    logic [2:0]    level;
    crp_pkg::res_t res;
    crp_pkg::res_t head;
    crp_pkg::res_t data;

    assign in_ready = not_full;
    assign take     = in_valid && in_ready;

    crp_front #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .ch           (ch),
        .end_of_stream(end_of_stream),
        .push         (push),
        .res          (res),
        .stopped      (stopped)
    );

    crp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(res),
        .pop      (pop),
        .head     (head),
        .not_empty(not_empty),
        .not_full (not_full),
        .level    (level)
    );

    crp_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .not_empty(not_empty),
        .pop      (pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .data     (data)
    );

    assign result_kind     = data.kind;
    assign payload_byte    = data.pbyte;
    assign byte_index      = data.idx;
    assign timestamp_value = data.ts;
    assign group_number    = data.grp;
    assign sender_address  = data.snd;
    assign byte_count      = data.cnt;
    assign text_line       = data.line;

    // Queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n) level <= 3'd4)
        else $error("result queue overflow");

    // An error item leaves the parser stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        push && res.kind == crp_pkg::RES_ERROR |=> stopped)
        else $error("parser not stopped after error");

    // A stopped parser produces nothing
    assert property (@(posedge clk) disable iff (!rst_n) stopped |-> !push)
        else $error("item produced while stopped");

    // Length is only reported on record completion
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != crp_pkg::RES_DONE |-> byte_count == 11'd0)
        else $error("byte count on non-completion item");

endmodule
